### src/gprf_pkg.sv
// Package for the gamepad report framer: event opcodes, register indexes,
// reset constants, dead-zone snap and CRC-8 step functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gprf_pkg;

  localparam logic [7:0] STICK_CENTER_RST = 8'h80;
  localparam logic [7:0] HAT_NEUTRAL_RST  = 8'h08;
  localparam logic [6:0] DEAD_ZONE_RST    = 7'd0;
  localparam logic [7:0] CRC_POLY         = 8'h07;
  localparam logic [7:0] CRC_INIT         = 8'h00;
  localparam logic [3:0] FRAME_LAST       = 4'd8;

  typedef enum logic [3:0] {
    OP_PRESS    = 4'd0,
    OP_RELEASE  = 4'd1,
    OP_SET_HAT  = 4'd2,
    OP_HAT_OFF  = 4'd3,
    OP_LEFT     = 4'd4,
    OP_RIGHT    = 4'd5,
    OP_FULL     = 4'd6,
    OP_RESET    = 4'd7,
    OP_SET_LX   = 4'd8,
    OP_SET_LY   = 4'd9,
    OP_SET_RX   = 4'd10,
    OP_SET_RY   = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    REG_DEAD_ZONE    = 2'd0,
    REG_STICK_CENTER = 2'd1,
    REG_HAT_NEUTRAL  = 2'd2
  } cfg_reg_t;

  // Values within dz of center snap to center.
  function automatic logic [7:0] snap_axis(input logic [7:0] v, input logic [7:0] center,
                                           input logic [6:0] dz);
    logic [7:0] diff;
    diff = (v >= center) ? (v - center) : (center - v);
    return (diff <= {1'b0, dz}) ? center : v;
  endfunction

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      x = x[7] ? ({x[6:0], 1'b0} ^ CRC_POLY) : {x[6:0], 1'b0};
    end
    return x;
  endfunction

endpackage

`default_nettype wire

### src/gprf_ifs.sv
// Channel interfaces for the gamepad report framer: event input,
// frame byte output and register write channel. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface gprf_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [15:0] button_mask;
  logic [7:0]  hat_value;
  logic [7:0]  left_x;
  logic [7:0]  left_y;
  logic [7:0]  right_x;
  logic [7:0]  right_y;
  logic [7:0]  vendor_value;
  logic        send_request;

  modport source (output valid, op, button_mask, hat_value, left_x, left_y, right_x,
                  right_y, vendor_value, send_request, input ready);
  modport sink (input valid, op, button_mask, hat_value, left_x, left_y, right_x,
                right_y, vendor_value, send_request, output ready);
endinterface

interface gprf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [3:0] byte_index;
  logic       frame_end;

  modport source (output valid, frame_byte, byte_index, frame_end, input ready);
  modport sink (input valid, frame_byte, byte_index, frame_end, output ready);
endinterface

interface gprf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/gamepad_report_framer_crc8.sv
// Gamepad report framer with CRC-8 (poly 0x07, init 0). A frame's first byte
// is offered the cycle after its request is accepted if no frame is active or
// the CRC byte is being taken. 1 request per cycle while the holding buffer is
// empty; a frame is the report bytes then the CRC byte, one byte per cycle
// while output is ready; one further frame can wait in the holding buffer.
// Reset: synchronous rst_n restores defaults, neutral state; no frame pending.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_report_framer_crc8
  import gprf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  gprf_cfg_if.sink    cfg_ch,
  gprf_in_if.sink     in_ch,
  gprf_out_if.source  out_ch
);

  // configuration
  logic [6:0] dead_zone_r;
  logic [7:0] stick_center_r;
  logic [7:0] hat_neutral_r;

  // gamepad state
  logic [15:0] buttons_r, buttons_nxt;
  logic [7:0]  hat_r, hat_nxt;
  logic [7:0]  axes_r [4];
  logic [7:0]  axes_nxt [4];
  logic [7:0]  vendor_r, vendor_nxt;
  logic [63:0] sent_report_r;
  logic        sent_valid_r;

  // serializer: active frame and one holding slot
  logic        act_valid_r;
  logic [63:0] act_bytes_r;
  logic [3:0]  act_idx_r;
  logic [7:0]  crc_r;
  logic        pend_valid_r;
  logic [63:0] pend_report_r;

  logic        in_fire, out_fire, cfg_fire;
  logic        op_ok, emit, act_free;
  logic [63:0] report_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;
  assign in_ch.ready  = !pend_valid_r;
  assign in_fire      = in_ch.valid && !pend_valid_r;
  assign out_fire     = out_ch.valid && out_ch.ready;

  always_comb begin
    buttons_nxt = buttons_r;
    hat_nxt     = hat_r;
    vendor_nxt  = vendor_r;
    for (int i = 0; i < 4; i++) axes_nxt[i] = axes_r[i];
    op_ok = 1'b1;
    unique case (op_t'(in_ch.op))
      OP_PRESS:   buttons_nxt = buttons_r | in_ch.button_mask;
      OP_RELEASE: buttons_nxt = buttons_r & ~in_ch.button_mask;
      OP_SET_HAT: hat_nxt = in_ch.hat_value;
      OP_HAT_OFF: hat_nxt = hat_neutral_r;
      OP_LEFT: begin
        axes_nxt[0] = snap_axis(in_ch.left_x, stick_center_r, dead_zone_r);
        axes_nxt[1] = snap_axis(in_ch.left_y, stick_center_r, dead_zone_r);
      end
      OP_RIGHT: begin
        axes_nxt[2] = snap_axis(in_ch.right_x, stick_center_r, dead_zone_r);
        axes_nxt[3] = snap_axis(in_ch.right_y, stick_center_r, dead_zone_r);
      end
      OP_FULL: begin
        axes_nxt[0] = snap_axis(in_ch.left_x, stick_center_r, dead_zone_r);
        axes_nxt[1] = snap_axis(in_ch.left_y, stick_center_r, dead_zone_r);
        axes_nxt[2] = snap_axis(in_ch.right_x, stick_center_r, dead_zone_r);
        axes_nxt[3] = snap_axis(in_ch.right_y, stick_center_r, dead_zone_r);
        hat_nxt     = in_ch.hat_value;
        buttons_nxt = in_ch.button_mask;
        vendor_nxt  = in_ch.vendor_value;
      end
      OP_RESET: begin
        for (int i = 0; i < 4; i++) axes_nxt[i] = stick_center_r;
        hat_nxt     = hat_neutral_r;
        buttons_nxt = '0;
        vendor_nxt  = '0;
      end
      // single axis from left_x; the partner axis is snapped again
      OP_SET_LX: begin
        axes_nxt[0] = snap_axis(in_ch.left_x, stick_center_r, dead_zone_r);
        axes_nxt[1] = snap_axis(axes_r[1], stick_center_r, dead_zone_r);
      end
      OP_SET_LY: begin
        axes_nxt[1] = snap_axis(in_ch.left_x, stick_center_r, dead_zone_r);
        axes_nxt[0] = snap_axis(axes_r[0], stick_center_r, dead_zone_r);
      end
      OP_SET_RX: begin
        axes_nxt[2] = snap_axis(in_ch.left_x, stick_center_r, dead_zone_r);
        axes_nxt[3] = snap_axis(axes_r[3], stick_center_r, dead_zone_r);
      end
      OP_SET_RY: begin
        axes_nxt[3] = snap_axis(in_ch.left_x, stick_center_r, dead_zone_r);
        axes_nxt[2] = snap_axis(axes_r[2], stick_center_r, dead_zone_r);
      end
      default: op_ok = 1'b0;
    endcase
  end

  assign report_nxt = {buttons_nxt, hat_nxt, axes_nxt[0], axes_nxt[1], axes_nxt[2],
                       axes_nxt[3], vendor_nxt};
  assign emit = in_fire && op_ok && in_ch.send_request &&
                (!sent_valid_r || (report_nxt != sent_report_r));
  assign act_free = !act_valid_r || (out_fire && (act_idx_r == FRAME_LAST));

  assign out_ch.valid      = act_valid_r;
  assign out_ch.frame_byte = (act_idx_r == FRAME_LAST) ? crc_r : act_bytes_r[63:56];
  assign out_ch.byte_index = act_idx_r;
  assign out_ch.frame_end  = (act_idx_r == FRAME_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r    <= DEAD_ZONE_RST;
      stick_center_r <= STICK_CENTER_RST;
      hat_neutral_r  <= HAT_NEUTRAL_RST;
      buttons_r      <= '0;
      hat_r          <= HAT_NEUTRAL_RST;
      for (int i = 0; i < 4; i++) axes_r[i] <= STICK_CENTER_RST;
      vendor_r       <= '0;
      sent_report_r  <= '0;
      sent_valid_r   <= 1'b0;
      act_valid_r    <= 1'b0;
      act_idx_r      <= '0;
      crc_r          <= CRC_INIT;
      pend_valid_r   <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          REG_DEAD_ZONE:    dead_zone_r    <= cfg_ch.data[6:0];
          REG_STICK_CENTER: stick_center_r <= cfg_ch.data;
          REG_HAT_NEUTRAL:  hat_neutral_r  <= cfg_ch.data;
          default: ;
        endcase
      end

      if (in_fire) begin
        buttons_r <= buttons_nxt;
        hat_r     <= hat_nxt;
        for (int i = 0; i < 4; i++) axes_r[i] <= axes_nxt[i];
        vendor_r  <= vendor_nxt;
      end
      if (emit) begin
        sent_report_r <= report_nxt;
        sent_valid_r  <= 1'b1;
      end

      // byte stream: CRC accumulates as each report byte leaves
      if (out_fire && (act_idx_r != FRAME_LAST)) begin
        act_bytes_r <= {act_bytes_r[55:0], 8'h00};
        act_idx_r   <= act_idx_r + 4'd1;
        crc_r       <= crc8_byte(crc_r, act_bytes_r[63:56]);
      end

      if (act_free) begin
        act_idx_r <= '0;
        crc_r     <= CRC_INIT;
        priority if (pend_valid_r) begin
          act_valid_r   <= 1'b1;
          act_bytes_r   <= pend_report_r;
          pend_valid_r  <= emit;
          pend_report_r <= report_nxt;
        end else if (emit) begin
          act_valid_r <= 1'b1;
          act_bytes_r <= report_nxt;
        end else begin
          act_valid_r <= 1'b0;
        end
      end else if (emit) begin
        pend_valid_r  <= 1'b1;
        pend_report_r <= report_nxt;
      end
    end
  end

  // A held frame implies a frame in flight.
  a_pend_needs_act: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> act_valid_r)
    else $error("holding slot full with no active frame");

  // No frame can exist before the first report is recorded.
  a_frame_after_sent: assert property (@(posedge clk) disable iff (!rst_n)
    act_valid_r |-> sent_valid_r)
    else $error("frame active without a recorded report");

  // A new frame with nothing in flight appears on the next cycle at byte 0.
  a_emit_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !act_valid_r) |=> (out_ch.valid && (out_ch.byte_index == '0)))
    else $error("frame did not start after request");

  // An accepted non-final byte advances the index by one.
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && (act_idx_r != FRAME_LAST)) |=> (act_idx_r == $past(act_idx_r) + 4'd1))
    else $error("byte index skipped");

endmodule

`default_nettype wire
